[rtl/core/krt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ID_W            = 32;
    localparam int QTY_W           = 32;
    localparam int CNT_W           = 7;
    localparam int CAP_W           = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [ID_W-1:0]  item_id;
        logic signed [QTY_W-1:0] quantity;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [QTY_W-1:0] found_quantity;
        logic [CNT_W-1:0]        entry_total;
    } t_res;

endpackage
`default_nettype wire

[rtl/core/krt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/core/krt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_ctrl
// Command sequencer: linear key search, read-modify-write, compaction shift.
// ----------------------------------------------------------------------------
module krt_ctrl #(
    parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire krt_pkg::t_req            i_req,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0] i_cap,
    output logic                          o_busy,
    output logic                          o_res_valid,
    output krt_pkg::t_res                 o_res,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_raddr,
    input  wire logic [krt_pkg::ID_W-1:0]  i_key_rdata,
    input  wire logic [krt_pkg::QTY_W-1:0] i_amt_rdata,
    output logic                          o_key_we,
    output logic                          o_amt_we,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_waddr,
    output logic [krt_pkg::ID_W-1:0]      o_key_wdata,
    output logic [krt_pkg::QTY_W-1:0]     o_amt_wdata
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > krt_pkg::CNT_W) ? CW : krt_pkg::CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]          r_state, n_state;
    krt_pkg::t_req       r_req, n_req;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ridx, n_ridx;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_paddr, n_paddr;
    logic                r_res_valid, n_res_valid;
    krt_pkg::t_res       r_res, n_res;

    logic                hit;
    logic                issue;
    logic [CW-1:0]       wpos;
    logic [EW-1:0]       cnt_ext;

    assign hit   = r_pend && (i_key_rdata == r_req.item_id);
    assign issue = (r_ridx < r_count);
    assign wpos  = r_paddr - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_ridx      = r_ridx;
        n_pend      = r_pend;
        n_paddr     = r_paddr;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_raddr     = r_ridx[AW-1:0];
        o_key_we    = 1'b0;
        o_amt_we    = 1'b0;
        o_waddr     = r_count[AW-1:0];
        o_key_wdata = r_req.item_id;
        o_amt_wdata = r_req.quantity;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_ridx  = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || (!r_pend && !issue)) begin
                    n_pend                   = 1'b0;
                    n_res_valid              = 1'b1;
                    n_res.status             = krt_pkg::ST_OK;
                    n_res.found_quantity     = '0;
                    n_state                  = S_IDLE;
                    if (r_req.command == krt_pkg::CMD_ADD) begin
                        if (r_count >= i_cap) begin
                            n_res.status = krt_pkg::ST_FULL;
                        end else if (hit) begin
                            n_res.status = krt_pkg::ST_DUP;
                        end else begin
                            o_key_we = 1'b1;
                            o_amt_we = 1'b1;
                            o_waddr  = r_count[AW-1:0];
                            n_count  = r_count + CW'(1);
                        end
                    end else if (!hit) begin
                        n_res.status = krt_pkg::ST_MISSING;
                    end else begin
                        case (r_req.command)
                            krt_pkg::CMD_LOOKUP: begin
                                n_res.found_quantity = i_amt_rdata;
                            end
                            krt_pkg::CMD_UPDATE: begin
                                o_waddr  = r_paddr[AW-1:0];
                                o_amt_we = !r_req.quantity[krt_pkg::QTY_W-1];
                            end
                            default: begin
                                // remove: compact the entries above the slot
                                n_ridx      = r_paddr + CW'(1);
                                n_res_valid = 1'b0;
                                n_state     = S_SHIFT;
                            end
                        endcase
                    end
                end else if (issue) begin
                    n_ridx  = r_ridx + CW'(1);
                    n_pend  = 1'b1;
                    n_paddr = r_ridx;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_key_we    = 1'b1;
                    o_amt_we    = 1'b1;
                    o_waddr     = wpos[AW-1:0];
                    o_key_wdata = i_key_rdata;
                    o_amt_wdata = i_amt_rdata;
                end
                if (issue) begin
                    n_ridx  = r_ridx + CW'(1);
                    n_pend  = 1'b1;
                    n_paddr = r_ridx;
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && !issue) begin
                    n_count              = r_count - CW'(1);
                    n_res_valid          = 1'b1;
                    n_res.status         = krt_pkg::ST_OK;
                    n_res.found_quantity = '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        cnt_ext = EW'(n_count);
        if (n_res_valid) begin
            n_res.entry_total = cnt_ext[krt_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_ridx  <= n_ridx;
        r_paddr <= n_paddr;
        r_res   <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

[rtl/core/keyed_record_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table
// Dense keyed record table with add, lookup, update and compacting remove.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on o_res for one cycle with o_res_valid, in the first cycle that busy
// is low again, and must be captured then since the receiver cannot hold it
// off. Keys and quantities live in two RAMs read at one address per cycle, so
// the keys are searched one per cycle, the search ending early when the key is
// found; a remove that hits then adds one read and one write per cycle for
// every entry above the removed slot. A new command is taken only once busy
// has fallen. The capacity register may be written whenever no command is
// in flight; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module keyed_record_table #(
    parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire krt_pkg::t_req             i_req,
    output logic                           o_res_valid,
    output krt_pkg::t_res                  o_res,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [krt_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > krt_pkg::CAP_W) ? CW : krt_pkg::CAP_W;

    logic [krt_pkg::CAP_W-1:0] r_cap;
    logic [EW-1:0]             cap_ext;
    logic [EW-1:0]             cap_eff;

    logic [AW-1:0]             raddr;
    logic [AW-1:0]             waddr;
    logic                      key_we;
    logic                      amt_we;
    logic [krt_pkg::ID_W-1:0]  key_wdata;
    logic [krt_pkg::QTY_W-1:0] amt_wdata;
    logic [krt_pkg::ID_W-1:0]  key_rdata;
    logic [krt_pkg::QTY_W-1:0] amt_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= krt_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // limit above the built depth acts as the depth
    assign cap_ext = EW'(r_cap);
    assign cap_eff = (cap_ext > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cap_ext;

    krt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_cap       (cap_eff[CW-1:0]),
        .o_busy      (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .o_raddr     (raddr),
        .i_key_rdata (key_rdata),
        .i_amt_rdata (amt_rdata),
        .o_key_we    (key_we),
        .o_amt_we    (amt_we),
        .o_waddr     (waddr),
        .o_key_wdata (key_wdata),
        .o_amt_wdata (amt_wdata)
    );

    krt_ram #(
        .WIDTH (krt_pkg::ID_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    krt_ram #(
        .WIDTH (krt_pkg::QTY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_amt_ram (
        .i_clk   (i_clk),
        .i_we    (amt_we),
        .i_waddr (waddr),
        .i_wdata (amt_wdata),
        .i_raddr (raddr),
        .o_rdata (amt_rdata)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_res_valid))
        else $error("accepted command did not raise busy");

    a_fail_no_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != krt_pkg::ST_OK)) |-> (o_res.found_quantity == '0))
        else $error("failed command reports a quantity");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (!key_we && !amt_we))
        else $error("memory written while idle");

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_record_table. A queue-fed driver issues
// table commands and capacity writes with random idle bursts; a software
// copy of the table predicts every result beat, and a monitor checks each
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import krt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int TAIL_ITEMS   = 200;
    localparam int POOL_SIZE    = 96;
    localparam int N_PHASES     = 8;

    localparam logic signed [ID_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic signed [ID_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic signed [ID_W-1:0] S_NEG = 32'hFFFF_FFFF;

    typedef struct {
        bit               is_cap;
        logic [CAP_W-1:0] cap;
        t_req             req;
    } t_table_op;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_req             i_req       = '0;
    logic             o_res_valid;
    t_res             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_data  = '0;

    t_table_op op_queue[$];
    t_res      outcome_queue[$];

    // software copy of the table
    logic signed [ID_W-1:0]  key_mem [MAX_ENTRIES_DEF];
    logic signed [QTY_W-1:0] qty_mem [MAX_ENTRIES_DEF];
    int                      held_count  = 0;
    int                      cap_setting = CAP_RESET;

    int issued_total   = 0;
    int received_total = 0;
    int mismatch_total = 0;
    int gap_left       = 0;
    int idle_cycles    = 0;
    bit feed_done      = 1'b0;

    logic signed [ID_W-1:0] id_pool [POOL_SIZE];

    // capacity, length, key pool size, add and remove percentages per phase
    int phase_cap  [N_PHASES] = '{64, 13, 1, 0, 127, 40, 2, 64};
    int phase_len  [N_PHASES] = '{300, 150, 120, 60, 300, 200, 120, 480};
    int phase_pool [N_PHASES] = '{80, 30, 8, 20, 90, 60, 6, 96};
    int phase_add  [N_PHASES] = '{70, 40, 45, 40, 50, 45, 45, 55};
    int phase_rem  [N_PHASES] = '{5, 25, 30, 30, 20, 25, 30, 15};

    keyed_record_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res table_outcome(input t_req op);
        t_res r;
        int   slot;
        int   lim;
        r      = '0;
        r.status = ST_OK;
        slot   = -1;
        lim    = (cap_setting > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : cap_setting;
        for (int i = 0; i < held_count; i++) begin
            if (slot < 0 && key_mem[i] == op.item_id) begin
                slot = i;
            end
        end
        if (op.command == CMD_ADD) begin
            if (held_count >= lim) begin
                r.status = ST_FULL;
            end else if (slot >= 0) begin
                r.status = ST_DUP;
            end else begin
                key_mem[held_count] = op.item_id;
                qty_mem[held_count] = op.quantity;
                held_count++;
            end
        end else if (slot < 0) begin
            r.status = ST_MISSING;
        end else if (op.command == CMD_LOOKUP) begin
            r.found_quantity = qty_mem[slot];
        end else if (op.command == CMD_UPDATE) begin
            if (!op.quantity[QTY_W-1]) begin
                qty_mem[slot] = op.quantity;
            end
        end else begin
            for (int j = slot; j + 1 < held_count; j++) begin
                key_mem[j] = key_mem[j+1];
                qty_mem[j] = qty_mem[j+1];
            end
            held_count--;
        end
        r.entry_total = CNT_W'(held_count);
        return r;
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input logic signed [ID_W-1:0] id,
                             input logic signed [QTY_W-1:0] qty);
        t_table_op op;
        op.is_cap           = 1'b0;
        op.cap              = '0;
        op.req.command      = cmd;
        op.req.item_id      = id;
        op.req.quantity     = qty;
        op_queue.push_back(op);
    endtask

    task automatic queue_cap(input logic [CAP_W-1:0] value);
        t_table_op op;
        op.is_cap = 1'b1;
        op.cap    = value;
        op.req    = '0;
        op_queue.push_back(op);
    endtask

    // stimulus and end of run
    initial begin
        int                      pick;
        logic [1:0]              cmd;
        logic signed [QTY_W-1:0] qty;

        id_pool[0] = S_MIN;
        id_pool[1] = S_MAX;
        id_pool[2] = '0;
        id_pool[3] = S_NEG;
        for (int i = 4; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom;
        end

        // zero capacity
        queue_cap(7'd0);
        queue_cmd(CMD_ADD, 32'sd5, 32'sd9);
        // capacity above the built depth
        queue_cap(7'd127);
        queue_cmd(CMD_ADD, S_MIN, S_MAX);
        queue_cmd(CMD_ADD, S_MAX, S_MIN);
        queue_cmd(CMD_ADD, '0, '0);
        queue_cmd(CMD_ADD, S_NEG, 32'sd1);
        queue_cmd(CMD_ADD, S_MIN, 32'sd3);
        queue_cmd(CMD_LOOKUP, S_MAX, '0);
        queue_cmd(CMD_LOOKUP, 32'sd12345, S_NEG);
        queue_cmd(CMD_UPDATE, S_MIN, -32'sd5);
        queue_cmd(CMD_LOOKUP, S_MIN, '0);
        queue_cmd(CMD_UPDATE, '0, S_MAX);
        queue_cmd(CMD_UPDATE, 32'sd777, 32'sd4);
        queue_cmd(CMD_REMOVE, 32'sd777, '0);
        queue_cmd(CMD_REMOVE, S_MAX, S_MIN);
        queue_cmd(CMD_LOOKUP, S_NEG, '0);
        // capacity lowered below the count
        queue_cap(7'd2);
        queue_cmd(CMD_ADD, 32'sd55, 32'sd6);
        queue_cmd(CMD_ADD, S_MIN, 32'sd6);
        queue_cmd(CMD_REMOVE, '0, '0);
        queue_cmd(CMD_ADD, 32'sd55, 32'sd6);
        queue_cmd(CMD_REMOVE, S_NEG, '0);
        queue_cmd(CMD_ADD, 32'sd55, 32'sd7);
        queue_cmd(CMD_LOOKUP, '0, '0);
        queue_cmd(CMD_LOOKUP, 32'sd55, '0);

        for (int p = 0; p < N_PHASES; p++) begin
            queue_cap(CAP_W'(phase_cap[p]));
            for (int k = 0; k < phase_len[p]; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < phase_add[p]) begin
                    cmd = CMD_ADD;
                end else if (pick < phase_add[p] + phase_rem[p]) begin
                    cmd = CMD_REMOVE;
                end else if ($urandom_range(0, 1) == 0) begin
                    cmd = CMD_LOOKUP;
                end else begin
                    cmd = CMD_UPDATE;
                end
                case ($urandom_range(0, 15))
                    0:       qty = S_MIN;
                    1:       qty = S_MAX;
                    2:       qty = '0;
                    3:       qty = S_NEG;
                    default: qty = $urandom;
                endcase
                queue_cmd(cmd, id_pool[$urandom_range(0, phase_pool[p] - 1)], qty);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(feed_done && issued_total == received_total)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_total == 0 && outcome_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // driver: commands and capacity writes
    always @(posedge i_clk) begin
        logic             nxt_start;
        logic             nxt_cfg;
        t_req             nxt_req;
        logic [CAP_W-1:0] nxt_cap;
        bit               took;
        t_table_op        op;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nxt_start = start;
            nxt_cfg   = i_cfg_valid;
            nxt_req   = i_req;
            nxt_cap   = i_cfg_data;
            took      = 1'b0;
            if (start && !busy) begin
                outcome_queue.push_back(table_outcome(i_req));
                issued_total <= issued_total + 1;
                nxt_start = 1'b0;
                took      = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cap_setting = i_cfg_data;
                nxt_cfg     = 1'b0;
                took        = 1'b1;
            end
            if (took && op_queue.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 12);
            end
            if (!nxt_start && !nxt_cfg && op_queue.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!op_queue[0].is_cap) begin
                    op        = op_queue.pop_front();
                    nxt_start = 1'b1;
                    nxt_req   = op.req;
                end else if (!took && issued_total == received_total) begin
                    // capacity changes only with no command in flight
                    op      = op_queue.pop_front();
                    nxt_cfg = 1'b1;
                    nxt_cap = op.cap;
                end
            end
            start       <= nxt_start;
            i_req       <= nxt_req;
            i_cfg_valid <= nxt_cfg;
            i_cfg_data  <= nxt_cap;
            feed_done   <= (op_queue.size() == 0) && !nxt_start && !nxt_cfg;
        end
    end

    // monitor: result beats
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            received_total <= received_total + 1;
            if (outcome_queue.size() == 0) begin
                if (mismatch_total < 10) begin
                    $display("unexpected result beat: status %0d qty %0d total %0d",
                             o_res.status, o_res.found_quantity, o_res.entry_total);
                end
                mismatch_total++;
            end else begin
                want = outcome_queue.pop_front();
                if (o_res.status !== want.status
                        || o_res.found_quantity !== want.found_quantity
                        || o_res.entry_total !== want.entry_total) begin
                    if (mismatch_total < 10) begin
                        $display("beat %0d: exp status %0d qty %0d total %0d, got %0d %0d %0d",
                                 received_total, want.status, want.found_quantity,
                                 want.entry_total, o_res.status, o_res.found_quantity,
                                 o_res.entry_total);
                    end
                    mismatch_total++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_res_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
